>>> rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_QUOTE   = 3'd0;
    localparam logic [2:0] ERR_ESC_END = 3'd1;
    localparam logic [2:0] ERR_TRUNC   = 3'd2;
    localparam logic [2:0] ERR_BADHEX  = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN = 3'd4;
    localparam logic [2:0] ERR_UNTERM  = 3'd5;

    // Depth of the result queue; one decoded item pushes at most MAX_RESULTS.
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [2:0] error_code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] res;
    } decode_t;

endpackage
`default_nettype wire

>>> rtl/jsu_decoder.sv
// String scanner state and the combinational decode of one input byte.
`default_nettype none
module jsu_decoder (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire logic           action,
    input  wire logic [7:0]     in_byte,
    output jsu_pkg::decode_t    dec
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      hex_cnt_reg, hex_cnt_next;
    logic [15:0]     acc_reg, acc_next;
    logic            inv_reg, inv_next;

    logic            hex_ok;
    logic [3:0]      hex_nib;
    logic [15:0]     code;

    function automatic jsu_pkg::result_t mk(input logic [1:0] kind, input logic [7:0] d,
                                            input logic [2:0] err, input logic last);
        jsu_pkg::result_t r;
        r.kind       = kind;
        r.data_byte  = d;
        r.error_code = err;
        r.last       = last;
        return r;
    endfunction

    always_comb begin
        hex_ok  = 1'b1;
        hex_nib = 4'h0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_nib = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            hex_nib = in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign code = {acc_reg[11:0], hex_nib};

    always_comb begin
        dec          = '0;
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        acc_next     = acc_reg;
        inv_next     = inv_reg;
        case (phase_reg)
            jsu_pkg::PH_IDLE: begin
                if (action || in_byte != CH_QUOTE) begin
                    dec.count  = 2'd1;
                    dec.res[0] = mk(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_QUOTE, 1'b1);
                end else begin
                    phase_next = jsu_pkg::PH_BODY;
                end
            end
            jsu_pkg::PH_BODY: begin
                dec.count = 2'd1;
                if (action) begin
                    dec.res[0] = mk(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_UNTERM, 1'b1);
                    phase_next = jsu_pkg::PH_IDLE;
                end else if (in_byte == CH_QUOTE) begin
                    dec.res[0] = mk(jsu_pkg::KIND_DONE, 8'h00, 3'd0, 1'b1);
                    phase_next = jsu_pkg::PH_IDLE;
                end else if (in_byte == CH_BSL) begin
                    dec.count  = 2'd0;
                    phase_next = jsu_pkg::PH_ESC;
                end else begin
                    dec.res[0] = mk(jsu_pkg::KIND_BYTE, in_byte, 3'd0, 1'b1);
                end
            end
            jsu_pkg::PH_ESC: begin
                dec.count  = 2'd1;
                phase_next = jsu_pkg::PH_BODY;
                if (action) begin
                    dec.res[0] = mk(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_ESC_END, 1'b1);
                    phase_next = jsu_pkg::PH_IDLE;
                end else begin
                    case (in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH:
                            dec.res[0] = mk(jsu_pkg::KIND_BYTE, in_byte, 3'd0, 1'b1);
                        8'h62: dec.res[0] = mk(jsu_pkg::KIND_BYTE, 8'h08, 3'd0, 1'b1);
                        8'h66: dec.res[0] = mk(jsu_pkg::KIND_BYTE, 8'h0C, 3'd0, 1'b1);
                        8'h6E: dec.res[0] = mk(jsu_pkg::KIND_BYTE, 8'h0A, 3'd0, 1'b1);
                        8'h72: dec.res[0] = mk(jsu_pkg::KIND_BYTE, 8'h0D, 3'd0, 1'b1);
                        8'h74: dec.res[0] = mk(jsu_pkg::KIND_BYTE, 8'h09, 3'd0, 1'b1);
                        8'h75: begin
                            dec.count    = 2'd0;
                            phase_next   = jsu_pkg::PH_HEX;
                            hex_cnt_next = 2'd0;
                            acc_next     = 16'h0000;
                            inv_next     = 1'b0;
                        end
                        default: begin
                            dec.res[0] = mk(jsu_pkg::KIND_ERR, 8'h00,
                                            jsu_pkg::ERR_UNKNOWN, 1'b1);
                            phase_next = jsu_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                if (action) begin
                    dec.count  = 2'd1;
                    dec.res[0] = mk(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_TRUNC, 1'b1);
                    phase_next = jsu_pkg::PH_IDLE;
                end else begin
                    acc_next = code;
                    inv_next = inv_reg | ~hex_ok;
                    if (hex_cnt_reg != 2'd3) begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end else begin
                        hex_cnt_next = 2'd0;
                        phase_next   = jsu_pkg::PH_BODY;
                        if (inv_next) begin
                            dec.count  = 2'd1;
                            dec.res[0] = mk(jsu_pkg::KIND_ERR, 8'h00,
                                            jsu_pkg::ERR_BADHEX, 1'b1);
                            phase_next = jsu_pkg::PH_IDLE;
                        end else if (code[15:7] == 9'd0) begin
                            dec.count  = 2'd1;
                            dec.res[0] = mk(jsu_pkg::KIND_BYTE, code[7:0], 3'd0, 1'b1);
                        end else if (code[15:11] == 5'd0) begin
                            dec.count  = 2'd2;
                            dec.res[0] = mk(jsu_pkg::KIND_BYTE,
                                            8'hC0 | {3'b000, code[10:6]}, 3'd0, 1'b0);
                            dec.res[1] = mk(jsu_pkg::KIND_BYTE,
                                            8'h80 | {2'b00, code[5:0]}, 3'd0, 1'b1);
                        end else if (code[15:11] == 5'b11011) begin
                            // Any surrogate half, paired or not: replacement character.
                            dec.count  = 2'd3;
                            dec.res[0] = mk(jsu_pkg::KIND_BYTE, 8'hEF, 3'd0, 1'b0);
                            dec.res[1] = mk(jsu_pkg::KIND_BYTE, 8'hBF, 3'd0, 1'b0);
                            dec.res[2] = mk(jsu_pkg::KIND_BYTE, 8'hBD, 3'd0, 1'b1);
                        end else begin
                            dec.count  = 2'd3;
                            dec.res[0] = mk(jsu_pkg::KIND_BYTE,
                                            8'hE0 | {4'h0, code[15:12]}, 3'd0, 1'b0);
                            dec.res[1] = mk(jsu_pkg::KIND_BYTE,
                                            8'h80 | {2'b00, code[11:6]}, 3'd0, 1'b0);
                            dec.res[2] = mk(jsu_pkg::KIND_BYTE,
                                            8'h80 | {2'b00, code[5:0]}, 3'd0, 1'b1);
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= jsu_pkg::PH_IDLE;
            hex_cnt_reg <= 2'd0;
            acc_reg     <= 16'h0000;
            inv_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            acc_reg     <= acc_next;
            inv_reg     <= inv_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/jsu_result_queue.sv
// Four-entry result queue: takes up to three results at once, gives one per cycle when popped.
`default_nettype none
module jsu_result_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire jsu_pkg::decode_t  dec,
    input  wire logic              pop,
    output jsu_pkg::result_t       head,
    output logic                   not_empty,
    output logic [2:0]             fill
);

    jsu_pkg::result_t entry_reg [jsu_pkg::QUEUE_DEPTH];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_n;

    assign push_n    = push ? dec.count : 2'd0;
    assign head      = entry_reg[head_reg];
    assign not_empty = (count_reg != 3'd0);
    assign fill      = count_reg;

    always_comb begin
        head_next  = pop ? head_reg + 2'd1 : head_reg;
        tail_next  = tail_reg + push_n;
        count_next = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < push_n) begin
                entry_reg[tail_reg + 2'(i)] <= dec.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/json_string_unescape_top.sv
// Top level of the JSON string unescaper: input register, decoder and result queue.
// A byte in the input register is decoded combinationally; its results enter the
// result queue once the queue has room, and the master side shows the queue's head.
// Throughput: one input transaction per cycle while the queue has room; a \u escape
// that expands to two or three UTF-8 bytes holds the input while the queue drains.
// Reset: aresetn is synchronous and active low; it empties the input register and
// the result queue and returns the scanner to waiting for an opening quote.
`default_nettype none
module json_string_unescape_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] action: 0 data byte, 1 end of input
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data_byte, [10:8] error_code, rest zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // final result caused by one input item
);

    // Input register: holds one accepted transaction until the queue has room for
    // every result it causes.
    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;

    jsu_pkg::decode_t dec;
    jsu_pkg::result_t head;
    logic             q_not_empty;
    logic [2:0]       q_fill;
    logic             fits;
    logic             advance;
    logic             pop;

    // The room test uses only registered state and the decode of the held byte,
    // so the ready path does not depend on m_tready.
    assign fits     = ({1'b0, dec.count} + q_fill) <= 3'(jsu_pkg::QUEUE_DEPTH);
    assign advance  = in_valid_reg && fits;
    assign s_tready = !in_valid_reg || fits;
    assign pop      = q_not_empty && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    jsu_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .action  (in_action_reg),
        .in_byte (in_byte_reg),
        .dec     (dec)
    );

    jsu_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .dec       (dec),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .fill      (q_fill)
    );

    // The master side shows the head of the queue directly from its registers.
    assign m_tvalid = q_not_empty;
    assign m_tdata  = {5'b00000, head.error_code, head.data_byte};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule
`default_nettype wire

>>> rtl/jsu_checker.sv
// Port-level checks of the JSON string unescaper and their binding to the top level.
`default_nettype none
module jsu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // A reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result transaction holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // Completion and errors always end the results of their input item.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == jsu_pkg::KIND_DONE || m_tuser == jsu_pkg::KIND_ERR)
        |-> m_tlast)
        else $error("status result without tlast");

    // Only errors carry an error code, and only decoded bytes carry data.
    a_fields_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != jsu_pkg::KIND_BYTE |-> m_tdata[7:0] == 8'h00
        && (m_tuser == jsu_pkg::KIND_ERR || m_tdata[10:8] == 3'd0))
        else $error("stray data or error code");

    // Unused bits of the result payload stay zero, and the unused kind 3 never appears.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:11] == 5'd0 && m_tuser != 2'd3)
        else $error("invalid result encoding");

endmodule

bind json_string_unescape_top jsu_checker u_checker (.*);
`default_nettype wire
